>>> hw/rtl/vsc_pkg.sv
// shared types and constants of the version string compare block
// no dependencies
`default_nettype none

package vsc_pkg;

    // scan modes of the back end
    localparam logic [1:0] MODE_TEXT  = 2'd0;
    localparam logic [1:0] MODE_INT   = 2'd1;
    localparam logic [1:0] MODE_FZERO = 2'd2;
    localparam logic [1:0] MODE_FDIG  = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // order codes, two's complement
    typedef logic [1:0] t_ord;
    localparam t_ord ORD_ZERO = 2'b00;
    localparam t_ord ORD_POS  = 2'b01;
    localparam t_ord ORD_NEG  = 2'b11;
    localparam t_ord ORD_BAD  = 2'b10;

    // queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // classified byte pair
    typedef struct packed {
        logic start;
        logic a_nul;
        logic b_nul;
        logic a_dig;
        logic b_dig;
        logic a_ch0;
        logic b_ch0;
        logic ne;
        t_ord cmp;
    } t_cls;

endpackage

`default_nettype wire

>>> hw/rtl/vsc_front.sv
// front end: accepts byte pairs and classifies them into one register
// depends on vsc_pkg
`default_nettype none

module vsc_front import vsc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_start_req,
    input  wire logic [7:0] i_byte_a,
    input  wire logic [7:0] i_byte_b,
    output logic            o_cls_valid,
    input  wire logic       i_cls_ready,
    output t_cls            o_cls
);

    logic r_valid;
    t_cls r_cls;
    t_cls n_cls;

    always_comb begin
        n_cls.start = i_start_req;
        n_cls.a_nul = (i_byte_a == CH_NUL);
        n_cls.b_nul = (i_byte_b == CH_NUL);
        n_cls.a_dig = (i_byte_a >= CH_ZERO) && (i_byte_a <= CH_NINE);
        n_cls.b_dig = (i_byte_b >= CH_ZERO) && (i_byte_b <= CH_NINE);
        n_cls.a_ch0 = (i_byte_a == CH_ZERO);
        n_cls.b_ch0 = (i_byte_b == CH_ZERO);
        n_cls.ne    = (i_byte_a != i_byte_b);
        if (i_byte_a > i_byte_b) begin
            n_cls.cmp = ORD_POS;
        end else if (i_byte_a < i_byte_b) begin
            n_cls.cmp = ORD_NEG;
        end else begin
            n_cls.cmp = ORD_ZERO;
        end
    end

    assign o_ready     = !r_valid || i_cls_ready;
    assign o_cls_valid = r_valid;
    assign o_cls       = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/vsc_queue.sv
// short fifo of classified items between front and back
// depends on vsc_pkg
`default_nettype none

module vsc_queue import vsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_cls,
    output logic      o_not_full,
    input  wire logic i_pop,
    output logic      o_not_empty,
    output t_cls      o_cls
);

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_not_full  = (r_count != QCNT_W'(QDEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cls       = r_mem[r_rd_ptr];
    assign push_ok     = i_push && o_not_full;
    assign pop_ok      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");
    a_count_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && !push_ok) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/vsc_back.sv
// back end: runs the scan mode machine and holds the result register
// depends on vsc_pkg
`default_nettype none

module vsc_back import vsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    output logic      o_q_pop,
    input  wire t_cls i_cls,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_ord      o_order
);

    logic [1:0] r_mode;
    t_ord       r_pend;
    logic       r_fin;
    logic       r_out_valid;
    t_ord       r_order;

    logic [1:0] n_mode;
    t_ord       n_pend;
    logic       n_fin;
    logic       emit;
    t_ord       emit_val;
    logic       go_text;
    logic       both_dig;

    assign both_dig = i_cls.a_dig && i_cls.b_dig;

    always_comb begin
        n_mode   = i_cls.start ? MODE_TEXT : r_mode;
        n_pend   = i_cls.start ? ORD_ZERO : r_pend;
        n_fin    = i_cls.start ? 1'b0 : r_fin;
        emit     = 1'b0;
        emit_val = ORD_ZERO;
        go_text  = 1'b0;
        if (!n_fin) begin
            case (n_mode)
                MODE_INT: begin
                    if (both_dig) begin
                        if (n_pend == ORD_ZERO) begin
                            n_pend = i_cls.cmp;
                        end
                    end else if (i_cls.a_dig) begin
                        emit = 1'b1; emit_val = ORD_POS;
                    end else if (i_cls.b_dig) begin
                        emit = 1'b1; emit_val = ORD_NEG;
                    end else if (n_pend != ORD_ZERO) begin
                        emit = 1'b1; emit_val = n_pend;
                    end else begin
                        go_text = 1'b1;
                    end
                end
                MODE_FZERO: begin
                    if (i_cls.a_ch0 && i_cls.b_ch0) begin
                        n_mode = MODE_FZERO;
                    end else if (i_cls.a_ch0) begin
                        emit = 1'b1; emit_val = ORD_NEG;
                    end else if (i_cls.b_ch0) begin
                        emit = 1'b1; emit_val = ORD_POS;
                    end else if (!i_cls.a_dig && i_cls.b_dig) begin
                        emit = 1'b1; emit_val = ORD_POS;
                    end else if (i_cls.a_dig && !i_cls.b_dig) begin
                        emit = 1'b1; emit_val = ORD_NEG;
                    end else if (both_dig) begin
                        n_mode = MODE_FDIG;
                        if (i_cls.ne) begin
                            emit = 1'b1; emit_val = i_cls.cmp;
                        end
                    end else begin
                        go_text = 1'b1;
                    end
                end
                MODE_FDIG: begin
                    if (both_dig) begin
                        if (i_cls.ne) begin
                            emit = 1'b1; emit_val = i_cls.cmp;
                        end
                    end else begin
                        go_text = 1'b1;
                    end
                end
                default: begin
                    go_text = 1'b1;
                end
            endcase
        end
        // plain byte compare, also entered when a digit run ends
        if (go_text) begin
            n_mode = MODE_TEXT;
            if (i_cls.a_nul || i_cls.b_nul) begin
                emit = 1'b1; emit_val = i_cls.cmp;
            end else if (!both_dig) begin
                if (i_cls.ne) begin
                    emit = 1'b1; emit_val = i_cls.cmp;
                end
            end else if (i_cls.a_ch0 && i_cls.b_ch0) begin
                n_mode = MODE_FZERO;
            end else if (i_cls.a_ch0) begin
                emit = 1'b1; emit_val = ORD_NEG;
            end else if (i_cls.b_ch0) begin
                emit = 1'b1; emit_val = ORD_POS;
            end else begin
                n_mode = MODE_INT;
                n_pend = i_cls.cmp;
            end
        end
        if (emit) begin
            n_fin = 1'b1;
        end
    end

    assign o_q_pop = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_order = r_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TEXT;
            r_pend      <= ORD_ZERO;
            r_fin       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_mode <= n_mode;
                r_pend <= n_pend;
                r_fin  <= n_fin;
            end
            if (o_q_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && emit) begin
            r_order <= emit_val;
        end
    end

`ifndef SYNTHESIS
    a_order_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_order != ORD_BAD))
        else $error("result holds an illegal order code");
    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && emit) |=> (r_fin && r_out_valid))
        else $error("decided comparison not marked finished");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/version_string_compare.sv
// top level of the version string compare block
// depends on vsc_pkg, vsc_front, vsc_queue and vsc_back
//
// usage:
//   input channel (i_valid / o_ready) carries one byte pair per item:
//   i_byte_a and i_byte_b are the next bytes of the two strings, and
//   i_start_req marks the first pair of a new comparison. a zero byte ends
//   its string. items arriving after a comparison has been decided are
//   dropped until the next item with i_start_req set
//   output channel (o_valid / i_ready) carries one item per comparison:
//   o_order is -1, 0 or +1, the sign of the version order of a against b
//   throughput: one byte pair per cycle while the output is not stalled; the mode
//   update in the back end is combinational, so the pipe never bubbles by itself
//   path: a deciding pair passes the front register, the four-entry queue and
//   the result register, in that order, before its result is on o_order
//   stall: while the result register is full and i_ready is low the back
//   end stops; the queue and front register still absorb up to five more
//   items before o_ready falls
//   reset: synchronous, active low; the block comes up idle, waiting for
//   an item with i_start_req set, with empty queue and no result pending
`default_nettype none

module version_string_compare import vsc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_start_req,
    input  wire logic [7:0]        i_byte_a,
    input  wire logic [7:0]        i_byte_b,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [1:0]      o_order
);

    // front register to queue
    logic cls_valid;
    logic cls_ready;
    t_cls front_cls;

    // queue to back end
    logic q_not_empty;
    logic q_pop;
    t_cls q_cls;
    t_ord back_order;

    vsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .i_byte_a    (i_byte_a),
        .i_byte_b    (i_byte_b),
        .o_cls_valid (cls_valid),
        .i_cls_ready (cls_ready),
        .o_cls       (front_cls)
    );

    // the queue lets the front keep taking items while the back is held
    vsc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (cls_valid),
        .i_cls       (front_cls),
        .o_not_full  (cls_ready),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_cls       (q_cls)
    );

    // back end pops one classified item per cycle while the queue holds one and
    // its result register is free or being emptied
    vsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_not_empty),
        .o_q_pop   (q_pop),
        .i_cls     (q_cls),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_order   (back_order)
    );

    assign o_order = $signed(back_order);

endmodule

`default_nettype wire

>>> sim/version_string_compare_tb.sv
// self-checking testbench for the version string compare block
// depends on vsc_pkg and version_string_compare; checks every order item against
// a cycle-free predictor of the version-order scan

module version_string_compare_tb;
    import vsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;  // cycles with no item moved on either side
    localparam int TAIL_CYCLES = 8;     // result register, queue and front stage
    localparam int MAX_REPORTS = 10;
    localparam int TOUR_LEN    = 25;
    localparam int STR_LEN     = 10;

    // outcome of judging one byte pair inside the scan
    typedef enum {VERDICT_OPEN, VERDICT_DONE, VERDICT_RETEXT} t_verdict;

    // one row of the directed tour; want is only used where typed is set
    typedef struct packed {
        logic       st;
        logic [7:0] a;
        logic [7:0] b;
        logic       typed;
        t_ord       want;
    } t_pair_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_start_req;
    logic [7:0]        i_byte_a;
    logic [7:0]        i_byte_b;
    logic              o_valid;
    logic              i_ready;
    logic signed [1:0] o_order;

    // predictor state: scan mode, first integer digit difference, decided flag
    logic [1:0] scan_mode;
    t_ord       digit_lead;
    bit         decided_now;

    // orders still owed by the block, oldest first
    t_ord orders_due [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int faults;
    int stall_cycles;
    int live_pairs;
    int dropped_pairs;
    int orders_seen;

    // directed tour: extremes, every mode and each special case of the scan
    t_pair_row tour_rows [0:TOUR_LEN-1] = '{
        // stray pair before any start is dropped
        '{1'b0, "a",   "b",   1'b0, ORD_ZERO},
        // two empty strings are equal
        '{1'b1, CH_NUL, CH_NUL, 1'b1, ORD_ZERO},
        // terminator against the highest byte, both ways
        '{1'b1, 8'hff, CH_NUL, 1'b1, ORD_POS},
        '{1'b1, CH_NUL, 8'hff, 1'b1, ORD_NEG},
        // comparison already decided, pair dropped
        '{1'b0, 8'h01, 8'h02, 1'b0, ORD_ZERO},
        // plain byte difference at the top of the range
        '{1'b1, 8'hff, 8'hfe, 1'b1, ORD_POS},
        // "12" vs "9": longer integer run wins
        '{1'b1, "1",   "9",   1'b0, ORD_ZERO},
        '{1'b0, "2",   CH_NUL, 1'b0, ORD_ZERO},
        // "15" vs "19": equal runs, first differing digit decides at run end
        '{1'b1, "1",   "1",   1'b0, ORD_ZERO},
        '{1'b0, "5",   "9",   1'b0, ORD_ZERO},
        '{1'b0, CH_NUL, CH_NUL, 1'b0, ORD_ZERO},
        // "7a" vs "7b": byte ending the run is judged again as text
        '{1'b1, "7",   "7",   1'b0, ORD_ZERO},
        '{1'b0, "a",   "b",   1'b0, ORD_ZERO},
        // "0" vs "09": side still holding a digit is smaller
        '{1'b1, "0",   "0",   1'b0, ORD_ZERO},
        '{1'b0, CH_NUL, "9",  1'b0, ORD_ZERO},
        // "001" vs "01": more leading zeros is smaller
        '{1'b1, "0",   "0",   1'b0, ORD_ZERO},
        '{1'b0, "0",   "1",   1'b0, ORD_ZERO},
        // "05" vs "07": fraction digits decide at once
        '{1'b1, "0",   "0",   1'b0, ORD_ZERO},
        '{1'b0, "5",   "7",   1'b0, ORD_ZERO},
        // restart while an integer run is open
        '{1'b1, "3",   "3",   1'b0, ORD_ZERO},
        '{1'b1, "z",   "z",   1'b0, ORD_ZERO},
        '{1'b0, CH_NUL, CH_NUL, 1'b0, ORD_ZERO},
        // "05x" vs "05y": fraction digit run ends in text
        '{1'b1, "0",   "0",   1'b0, ORD_ZERO},
        '{1'b0, "5",   "5",   1'b0, ORD_ZERO},
        '{1'b0, "x",   "y",   1'b0, ORD_ZERO}
    };

    version_string_compare DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .i_byte_a    (i_byte_a),
        .i_byte_b    (i_byte_b),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_order     (o_order)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic t_ord order_of(input logic [7:0] a, input logic [7:0] b);
        if (a > b) return ORD_POS;
        if (a < b) return ORD_NEG;
        return ORD_ZERO;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // leading-zero stage of a fraction; hands non-digit pairs back to text
    function automatic t_verdict zero_run(input logic [7:0] a, input logic [7:0] b,
                                          output t_ord ord);
        bit za, zb, da, db;
        za  = (a == CH_ZERO);
        zb  = (b == CH_ZERO);
        da  = is_num(a);
        db  = is_num(b);
        ord = ORD_ZERO;
        if (za && zb) begin
            scan_mode = MODE_FZERO;
            return VERDICT_OPEN;
        end
        // a zero against a nonzero: more leading zeros is smaller
        if (za) begin
            ord = ORD_NEG;
            return VERDICT_DONE;
        end
        if (zb) begin
            ord = ORD_POS;
            return VERDICT_DONE;
        end
        // zeros equal and one side out of digits: that side ranks higher
        if (!da && db) begin
            ord = ORD_POS;
            return VERDICT_DONE;
        end
        if (da && !db) begin
            ord = ORD_NEG;
            return VERDICT_DONE;
        end
        if (da && db) begin
            scan_mode = MODE_FDIG;
            ord       = order_of(a, b);
            return (a != b) ? VERDICT_DONE : VERDICT_OPEN;
        end
        scan_mode = MODE_TEXT;
        return VERDICT_RETEXT;
    endfunction

    // byte pair judged outside any digit run
    function automatic t_verdict text_pair(input logic [7:0] a, input logic [7:0] b,
                                           output t_ord ord);
        scan_mode = MODE_TEXT;
        ord       = order_of(a, b);
        if (a == CH_NUL || b == CH_NUL) return VERDICT_DONE;
        if (!is_num(a) || !is_num(b)) return (a != b) ? VERDICT_DONE : VERDICT_OPEN;
        // both digits here, so the zero stage never hands back
        if (a == CH_ZERO || b == CH_ZERO) return zero_run(a, b, ord);
        scan_mode  = MODE_INT;
        digit_lead = ord;
        return VERDICT_OPEN;
    endfunction

    // advances the scan by one accepted pair; 1 when an order item is due
    function automatic bit judge_pair(input bit st, input logic [7:0] a,
                                      input logic [7:0] b, output t_ord ord);
        t_verdict v;
        bit       da, db;
        da  = is_num(a);
        db  = is_num(b);
        ord = ORD_ZERO;
        if (st) begin
            scan_mode   = MODE_TEXT;
            digit_lead  = ORD_ZERO;
            decided_now = 1'b0;
        end
        if (decided_now) return 1'b0;
        case (scan_mode)
            MODE_INT: begin
                if (da && db) begin
                    if (digit_lead == ORD_ZERO) digit_lead = order_of(a, b);
                    v = VERDICT_OPEN;
                end else if (da) begin
                    ord = ORD_POS;
                    v   = VERDICT_DONE;
                end else if (db) begin
                    ord = ORD_NEG;
                    v   = VERDICT_DONE;
                end else if (digit_lead != ORD_ZERO) begin
                    ord = digit_lead;
                    v   = VERDICT_DONE;
                end else begin
                    v = text_pair(a, b, ord);
                end
            end
            MODE_FZERO: begin
                v = zero_run(a, b, ord);
                if (v == VERDICT_RETEXT) v = text_pair(a, b, ord);
            end
            MODE_FDIG: begin
                if (da && db) begin
                    ord = order_of(a, b);
                    v   = (a != b) ? VERDICT_DONE : VERDICT_OPEN;
                end else begin
                    v = text_pair(a, b, ord);
                end
            end
            default: begin
                v = text_pair(a, b, ord);
            end
        endcase
        decided_now = (v == VERDICT_DONE);
        return decided_now;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // offers one byte pair, holds it until taken, then books what it owes
    task automatic send_pair(input bit st, input logic [7:0] a, input logic [7:0] b,
                             input bit typed, input t_ord want, output bit decided);
        t_ord ord;
        // a gap before the item, never lowering and raising valid in one step
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid     <= 1'b1;
        i_start_req <= st;
        i_byte_a    <= a;
        i_byte_b    <= b;
        do @(posedge i_clk); while (!o_ready);
        if (st || !decided_now) begin
            live_pairs++;
        end else begin
            dropped_pairs++;
        end
        decided = judge_pair(st, a, b, ord);
        if (decided) orders_due.push_back(typed ? want : ord);
    endtask

    // mostly zeros and digits so that integer and fraction runs come up often
    function automatic logic [7:0] draw_char();
        case ($urandom_range(9))
            0, 1, 2: return CH_ZERO;
            3, 4, 5: return 8'($urandom_range(CH_NINE, CH_ZERO + 1));
            6:       return ".";
            7:       return 8'($urandom_range("c", "a"));
            default: return 8'($urandom_range(255, 1));
        endcase
    endfunction

    // string pairs with random content until goal pairs have been scanned
    task automatic run_strings(input int goal);
        logic [7:0] sa [0:STR_LEN-1];
        logic [7:0] sb [0:STR_LEN-1];
        int         first, la, lb, kind, cut, k;
        bit         st, decided;
        first = live_pairs;
        while (live_pairs - first < goal) begin
            kind = $urandom_range(99);
            la   = $urandom_range(STR_LEN - 2);
            lb   = ($urandom_range(1) == 1) ? la : $urandom_range(STR_LEN - 2);
            // b mostly copies a, so prefixes match and the scan gets deep
            for (k = 0; k < STR_LEN; k++) begin
                sa[k] = (k < la) ? draw_char() : CH_NUL;
                if (k >= lb) begin
                    sb[k] = CH_NUL;
                end else if (k < la && $urandom_range(3) != 0) begin
                    sb[k] = sa[k];
                end else begin
                    sb[k] = draw_char();
                end
            end
            // 80 whole strings, 10 cut short before the end, 10 raw byte noise
            cut     = (kind >= 80 && kind < 90) ? $urandom_range(la) : STR_LEN;
            decided = 1'b0;
            for (k = 0; k < cut && !decided; k++) begin
                st = (k == 0);
                if (kind >= 90) begin
                    sa[k] = 8'($urandom_range(255));
                    sb[k] = 8'($urandom_range(255));
                    st    = st || ($urandom_range(9) == 0);
                end
                send_pair(st, sa[k], sb[k], 1'b0, ORD_ZERO, decided);
            end
            // stray pair: dropped when decided, continues a cut comparison otherwise
            if ($urandom_range(4) == 0) begin
                send_pair(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          1'b0, ORD_ZERO, decided);
            end
        end
    endtask

    // ---------------------------------------------------------------- checking

    // receiver: takes order items and randomly stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            orders_seen++;
            if (orders_due.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS) begin
                    $display("%0t: order item %0d with none due, got %0d",
                             $realtime, orders_seen, o_order);
                end
            end else if (o_order !== orders_due[0]) begin
                faults++;
                if (faults <= MAX_REPORTS) begin
                    $display("%0t: order item %0d expected %0d, got %0d",
                             $realtime, orders_seen, $signed(orders_due[0]), o_order);
                end
                void'(orders_due.pop_front());
            end else begin
                void'(orders_due.pop_front());
            end
        end
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog: ends the run when no item moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("version_string_compare regression: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        bit decided;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_start_req   = 1'b0;
        i_byte_a      = CH_NUL;
        i_byte_b      = CH_NUL;
        i_ready       = 1'b0;
        scan_mode     = MODE_TEXT;
        digit_lead    = ORD_ZERO;
        decided_now   = 1'b1;
        faults        = 0;
        stall_cycles  = 0;
        live_pairs    = 0;
        dropped_pairs = 0;
        orders_seen   = 0;
        tx_idle_pct   = 37;
        rx_idle_pct   = 86;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed tour, run under the first idling pattern
        for (int k = 0; k < TOUR_LEN; k++) begin
            send_pair(tour_rows[k].st, tour_rows[k].a, tour_rows[k].b,
                      tour_rows[k].typed, tour_rows[k].want, decided);
        end

        // random strings: slow receiver, then slow sender, then full rate
        run_strings(170);
        tx_idle_pct = 86;
        rx_idle_pct = 37;
        run_strings(170);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_strings(170);
        i_valid <= 1'b0;

        // drain, then give the pipe time to show anything extra
        while (orders_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("scanned %0d byte pairs, %0d dropped while idle", live_pairs, dropped_pairs);
        $display("checked %0d order items, %0d mismatches", orders_seen, faults);
        if (faults == 0) begin
            $display("version_string_compare regression: pass");
        end else begin
            $display("version_string_compare regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/vsc_pkg.sv
hw/rtl/vsc_front.sv
hw/rtl/vsc_queue.sv
hw/rtl/vsc_back.sv
hw/rtl/version_string_compare.sv
sim/version_string_compare_tb.sv
